@@ design/fpq8_pkg.sv @@
// Package for the Q24.8 fixed-point ALU: action codes, field widths,
// shared item structures. No dependencies.
package fpq8_pkg;

    localparam int FracBits  = 8;
    localparam int WordWidth = 32;
    localparam int IoWidth   = 32;
    localparam int ActWidth  = 4;
    localparam int QueueDepth = 4;

    typedef enum logic [ActWidth-1:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_MIN      = 4'd4,
        ACT_MAX      = 4'd5,
        ACT_INC      = 4'd6,
        ACT_DEC      = 4'd7,
        ACT_TO_INT   = 4'd8,
        ACT_FROM_INT = 4'd9
    } action_t;

    typedef struct packed {
        logic [ActWidth-1:0] action;
        logic signed [IoWidth-1:0] operand_a;
        logic signed [IoWidth-1:0] operand_b;
        logic a_less;
        logic a_equal;
        logic a_greater;
    } item_t;

    typedef struct packed {
        logic signed [IoWidth-1:0] result;
        logic a_less;
        logic a_equal;
        logic a_greater;
        logic overflow;
        logic divide_by_zero;
    } res_t;

endpackage

@@ design/fpq8_front.sv @@
// Front stage: registers an accepted item and its comparison flags.
// Depends on fpq8_pkg.
module fpq8_front
#(
    parameter int WORD_WIDTH = fpq8_pkg::WordWidth
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpq8_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output fpq8_pkg::item_t  out_item
);
    localparam int INB = (WORD_WIDTH < fpq8_pkg::IoWidth) ? WORD_WIDTH : fpq8_pkg::IoWidth;

    logic            valid_reg;
    fpq8_pkg::item_t item_reg;
    fpq8_pkg::item_t item_next;
    logic signed [INB-1:0] a, b;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        a                   = in_item.operand_a[INB-1:0];
        b                   = in_item.operand_b[INB-1:0];
        item_next           = in_item;
        item_next.a_less    = a < b;
        item_next.a_equal   = a == b;
        item_next.a_greater = a > b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end
endmodule

@@ design/fpq8_queue.sv @@
// Small FIFO between front and back stages.
// Depends on fpq8_pkg.
module fpq8_queue
#(
    parameter int DEPTH = fpq8_pkg::QueueDepth
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpq8_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output fpq8_pkg::item_t  out_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fpq8_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_item;
    end

`ifndef ASSERT_OFF
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance on push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> wr_reg == rd_reg)
        else $error("empty queue with unequal pointers");
`endif
endmodule

@@ design/fpq8_back.sv @@
// Back end: pipelined execution of ALU actions; multiply and divide use
// multi-stage units (divider one quotient bit per stage). Depends on fpq8_pkg.
module fpq8_back
#(
    parameter int FRAC_BITS  = fpq8_pkg::FracBits,
    parameter int WORD_WIDTH = fpq8_pkg::WordWidth
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpq8_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output fpq8_pkg::res_t   out_res
);
    localparam int IW  = fpq8_pkg::IoWidth;
    localparam int W   = WORD_WIDTH;
    localparam int INB = (W < IW) ? W : IW;
    localparam int MW  = W;                    // operand magnitude width
    localparam int NW  = W + FRAC_BITS;        // dividend width
    localparam int QW  = NW;                   // quotient width
    localparam int PW  = 2 * W;                // product width
    localparam int HW  = (W + 1) / 2;          // low multiplier half
    localparam int HH  = W - HW;
    localparam int STG = QW + 3;               // pipeline length
    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [fpq8_pkg::ActWidth-1:0] action;
        logic          neg;
        logic          fast_ovf;
        logic          dbz;
        logic signed [W-1:0] fast;
        logic [MW-1:0] mb;
        logic [NW-1:0] num;
        logic [MW:0]   rem;
        logic [QW-1:0] q;
        logic [PW-1:0] prod;
        logic          a_less;
        logic          a_equal;
        logic          a_greater;
    } stg_t;

    logic   adv;
    logic   v_reg [STG];
    stg_t   s_reg [STG];
    stg_t   s_next [STG];
    stg_t   s0;
    logic signed [W-1:0] a, b;
    logic [MW-1:0] ma, mb;
    logic signed [W:0] sum, dif;
    logic signed [W-1:0] fi_lim;

    assign adv      = !v_reg[STG-1] || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        a   = W'(signed'(in_item.operand_a[INB-1:0]));
        b   = W'(signed'(in_item.operand_b[INB-1:0]));
        ma  = a[W-1] ? MW'(-a) : MW'(a);
        mb  = b[W-1] ? MW'(-b) : MW'(b);
        sum = (W+1)'(a) + (W+1)'(b);
        dif = (W+1)'(a) - (W+1)'(b);
        fi_lim = MAXV >>> FRAC_BITS;
        s0  = '0;
        s0.action    = in_item.action;
        s0.neg       = a[W-1] ^ b[W-1];
        s0.mb        = mb;
        s0.num       = {ma, FRAC_BITS'(0)};
        s0.a_less    = in_item.a_less;
        s0.a_equal   = in_item.a_equal;
        s0.a_greater = in_item.a_greater;
        unique case (in_item.action)
            fpq8_pkg::ACT_ADD:
            begin
                s0.fast_ovf = sum[W] != sum[W-1];
                s0.fast = s0.fast_ovf ? (sum[W] ? MINV : MAXV) : sum[W-1:0];
            end
            fpq8_pkg::ACT_SUB:
            begin
                s0.fast_ovf = dif[W] != dif[W-1];
                s0.fast = s0.fast_ovf ? (dif[W] ? MINV : MAXV) : dif[W-1:0];
            end
            fpq8_pkg::ACT_DIV:
            begin
                if (b == '0)
                begin
                    s0.dbz  = 1'b1;
                    s0.fast = (a == '0) ? '0 : (a[W-1] ? MINV : MAXV);
                end
            end
            fpq8_pkg::ACT_MIN:  s0.fast = in_item.a_less ? a : b;
            fpq8_pkg::ACT_MAX:  s0.fast = in_item.a_greater ? a : b;
            fpq8_pkg::ACT_INC:
            begin
                s0.fast_ovf = a == MAXV;
                s0.fast = s0.fast_ovf ? MAXV : a + 1'b1;
            end
            fpq8_pkg::ACT_DEC:
            begin
                s0.fast_ovf = a == MINV;
                s0.fast = s0.fast_ovf ? MINV : a - 1'b1;
            end
            fpq8_pkg::ACT_TO_INT: s0.fast = a >>> FRAC_BITS;
            fpq8_pkg::ACT_FROM_INT:
            begin
                if (a > fi_lim)
                begin
                    s0.fast_ovf = 1'b1;
                    s0.fast = MAXV;
                end
                else if (a < (MINV >>> FRAC_BITS))
                begin
                    s0.fast_ovf = 1'b1;
                    s0.fast = MINV;
                end
                else
                    s0.fast = a <<< FRAC_BITS;
            end
            default: s0.fast = '0;
        endcase
        // low multiplier partial product registered in stage 0
        s0.prod = PW'(ma[HW-1:0]) * PW'(mb);
        s0.q    = QW'(ma[W-1:HW]) ;
    end

    // stage 0: low partial product; stage 1: high partial product added;
    // then one quotient bit per stage; the last stage adds the rounding
    always_comb
    begin
        s_next[0]      = s0;
        s_next[1]      = s_reg[0];
        s_next[1].prod = s_reg[0].prod
            + ((PW'(s_reg[0].q[HH-1:0]) * PW'(s_reg[0].mb)) << HW);
        s_next[1].q    = '0;
        for (int i = 2; i < STG - 1; i++)
        begin
            s_next[i]     = s_reg[i-1];
            s_next[i].rem = {s_reg[i-1].rem[MW-1:0], s_reg[i-1].num[NW-1]};
            s_next[i].q   = {s_reg[i-1].q[QW-2:0], 1'b0};
            if (s_next[i].rem >= {1'b0, s_reg[i-1].mb})
            begin
                s_next[i].rem  = s_next[i].rem - {1'b0, s_reg[i-1].mb};
                s_next[i].q[0] = 1'b1;
            end
            s_next[i].num = {s_reg[i-1].num[NW-2:0], 1'b0};
        end
        s_next[STG-1] = s_reg[STG-2];
        // round half away: rem >= mb - rem
        if ((MW+1)'(s_reg[STG-2].rem) >= (MW+1)'(s_reg[STG-2].mb)
            - (MW+1)'(s_reg[STG-2].rem))
            s_next[STG-1].q = s_reg[STG-2].q + 1'b1;
        s_next[STG-1].prod = s_reg[STG-2].prod
            + PW'(1 << (FRAC_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STG; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < STG; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STG; i++)
                s_reg[i] <= s_next[i];
        end
    end

    stg_t  l;
    logic [PW:0] mag;
    logic [PW:0] lim;
    logic signed [W-1:0] r;
    logic  ovf;

    always_comb
    begin
        l   = s_reg[STG-1];
        lim = l.neg ? (PW+1)'({1'b0, MAXV}) + 1'b1 : (PW+1)'({1'b0, MAXV});
        mag = '0;
        r   = l.fast;
        ovf = l.fast_ovf;
        if (l.action == fpq8_pkg::ACT_MUL)
            mag = (PW+1)'(l.prod >> FRAC_BITS);
        else if (l.action == fpq8_pkg::ACT_DIV)
            mag = (PW+1)'(l.q);
        if ((l.action == fpq8_pkg::ACT_MUL)
            || (l.action == fpq8_pkg::ACT_DIV && !l.dbz))
        begin
            ovf = mag > lim;
            if (ovf)
                mag = lim;
            r = l.neg ? W'(-mag) : W'(mag);
        end
        out_res.result         = IW'(r);
        out_res.a_less         = l.a_less;
        out_res.a_equal        = l.a_equal;
        out_res.a_greater      = l.a_greater;
        out_res.overflow       = ovf;
        out_res.divide_by_zero = l.dbz;
    end

    assign out_valid = v_reg[STG-1];

`ifndef ASSERT_OFF
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({out_res.a_less, out_res.a_equal, out_res.a_greater}))
        else $error("comparison flags not one-hot");
    a_dbz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.divide_by_zero |-> !out_res.overflow)
        else $error("divide by zero with overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_res))
        else $error("result changed while stalled");
`endif
endmodule

@@ design/fixed_point_q8_alu.sv @@
// Q24.8 fixed-point ALU top level: front stage, queue, execution pipeline.
// Throughput: one transfer per cycle unless m_axis_tready stalls the output; the divider has a stage per quotient bit.
// Reset: rst_n asynchronous active low clears all valid and queue state.
// Depends on fpq8_pkg, fpq8_front, fpq8_queue, fpq8_back.
module fixed_point_q8_alu
#(
    parameter int FRAC_BITS  = fpq8_pkg::FracBits,
    parameter int WORD_WIDTH = fpq8_pkg::WordWidth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // action[3:0], operand_a[35:4], operand_b[67:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // result[31:0], a_less, a_equal, a_greater,
                                        // overflow, divide_by_zero
);
    fpq8_pkg::item_t in_item, f_item, q_item;
    fpq8_pkg::res_t  res;
    logic f_valid, f_ready, q_valid, q_ready;

    always_comb
    begin
        in_item           = '0;
        in_item.action    = s_axis_tdata[3:0];
        in_item.operand_a = s_axis_tdata[35:4];
        in_item.operand_b = s_axis_tdata[67:36];
    end

    fpq8_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    fpq8_queue u_queue (
        .clk, .rst_n,
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    fpq8_back #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_back (
        .clk, .rst_n,
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {3'b000, res.divide_by_zero, res.overflow,
                           res.a_greater, res.a_equal, res.a_less, res.result};
endmodule
